FILE: hdl/nkts_pkg.sv
// shared types and codes for the name keyed table store
// no dependencies; imported by every module of the block
`default_nettype none

package nkts_pkg;

    localparam int unsigned KEY_IN_BITS  = 64;
    localparam int unsigned DATA_IN_BITS = 32;

    // request actions
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_UNSET = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADNAME  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SCAN,
        S_TAIL,
        S_WB
    } t_state;

    // status from the name normalizer
    typedef struct packed {
        logic done;
        logic bad;
    } t_norm_stat;

endpackage

`default_nettype wire

FILE: hdl/name_keyed_table_store.sv
// top level of the name keyed table store: request control, table memories, result register
// depends on nkts_pkg and nkts_norm
`default_nettype none

// Each request (set, get or unset of a short name key) gives exactly one
// result transfer. From its input transfer to its result a request passes
// through the byte-serial name normalizer (eight bytes, one per cycle), the
// scan through the table entries in turn over the single read port of the
// name and data memories, a tail state for the last read to land and a
// write-back state that waits for the result register to be free. A
// request with an empty or too long name, or the unused action code, skips
// the scan. One request is in work at a time; the result register lets the
// next request enter while a result still waits to be taken. Reset clears
// the per-entry valid flags, so the table is empty right after reset with
// no clearing pass.
module name_keyed_table_store #(
    parameter int unsigned TABLE_ENTRIES = 16,
    parameter int unsigned NAME_CHARS    = 8,
    parameter int unsigned DATA_BITS     = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_action,
    input  wire logic [nkts_pkg::KEY_IN_BITS-1:0]    i_name_key,
    input  wire logic [nkts_pkg::DATA_IN_BITS-1:0]   i_write_data,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [1:0]                               o_status,
    output logic [nkts_pkg::DATA_IN_BITS-1:0]        o_read_data
);
    import nkts_pkg::*;

    localparam int unsigned IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned KEY_BITS   = 8 * NAME_CHARS;
    localparam int unsigned STORE_BITS = (DATA_BITS < DATA_IN_BITS) ? DATA_BITS : DATA_IN_BITS;

    // table storage: names and data in memories, set flags in flip-flops
    logic [KEY_BITS-1:0]   mem_name [TABLE_ENTRIES];
    logic [STORE_BITS-1:0] mem_data [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    t_state r_state, n_state;

    // request held for the whole operation
    logic [1:0]            r_action;
    logic [STORE_BITS-1:0] r_wdata;
    logic                  r_skip;

    // scan pipeline
    logic [IDX_W-1:0]      r_addr;
    logic                  r_chk;
    logic [IDX_W-1:0]      r_chk_addr;
    logic [KEY_BITS-1:0]   r_rd_name;
    logic [STORE_BITS-1:0] r_rd_data;
    logic                  r_rd_valid;

    // scan findings
    logic                  r_found;
    logic [IDX_W-1:0]      r_match_idx;
    logic [STORE_BITS-1:0] r_hit_data;
    logic                  r_free;
    logic [IDX_W-1:0]      r_free_idx;

    // result register
    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic [DATA_IN_BITS-1:0] r_read_data;

    // normalizer link
    t_norm_stat          norm_stat;
    logic [KEY_BITS-1:0] norm_key;

    // control decodes
    logic in_xfer;
    logic out_free;
    logic rd_en;
    logic wb_fire;
    logic last_addr;
    logic hit;

    // write-back decisions
    logic [1:0]              wb_status;
    logic [DATA_IN_BITS-1:0] wb_rdata;
    logic                    wb_write;
    logic                    wb_clear;
    logic [IDX_W-1:0]        wb_idx;

    nkts_norm #(
        .NAME_CHARS (NAME_CHARS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_key   (i_name_key),
        .o_stat  (norm_stat),
        .o_key   (norm_key)
    );

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_addr = (r_addr == IDX_W'(TABLE_ENTRIES - 1));
    assign in_xfer   = i_in_valid && !o_in_stall;
    assign hit       = r_rd_valid && (r_rd_name == norm_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (norm_stat.done) begin
                    if (r_action == ACT_NOP || norm_stat.bad) begin
                        n_state = S_WB;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (last_addr) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        wb_fire    = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_SCAN: rd_en      = 1'b1;
            S_WB:   wb_fire    = out_free;
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // what the write-back does with the scan findings
    always_comb begin
        wb_status = ST_OK;
        wb_rdata  = '0;
        wb_write  = 1'b0;
        wb_clear  = 1'b0;
        wb_idx    = r_found ? r_match_idx : r_free_idx;
        if (r_action == ACT_NOP) begin
            wb_status = ST_OK;
        end else if (r_skip) begin
            wb_status = ST_BADNAME;
        end else begin
            case (r_action)
                ACT_SET: begin
                    if (r_found || r_free) begin
                        wb_write = 1'b1;
                    end else begin
                        wb_status = ST_FULL;
                    end
                end
                ACT_GET: begin
                    if (r_found) begin
                        wb_rdata = DATA_IN_BITS'(r_hit_data);
                    end else begin
                        wb_status = ST_NOTFOUND;
                    end
                end
                ACT_UNSET: begin
                    if (r_found) begin
                        wb_clear = 1'b1;
                    end else begin
                        wb_status = ST_NOTFOUND;
                    end
                end
                default: begin
                    wb_status = ST_OK;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_chk       <= 1'b0;
            r_found     <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
            r_skip      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= rd_en;

            if (in_xfer) begin
                r_found <= 1'b0;
                r_free  <= 1'b0;
            end else if (r_chk) begin
                // first match and lowest unset slot win
                if (hit && !r_found) begin
                    r_found <= 1'b1;
                end
                if (!r_rd_valid && !r_free) begin
                    r_free <= 1'b1;
                end
            end

            if (r_state == S_NORM && norm_stat.done) begin
                r_skip <= norm_stat.bad;
            end

            if (wb_fire && wb_write) begin
                r_valid[wb_idx] <= 1'b1;
            end else if (wb_fire && wb_clear) begin
                r_valid[wb_idx] <= 1'b0;
            end

            if (wb_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action <= i_action;
            r_wdata  <= i_write_data[STORE_BITS-1:0];
        end

        if (r_state == S_NORM) begin
            r_addr <= '0;
        end else if (rd_en && !last_addr) begin
            r_addr <= r_addr + IDX_W'(1);
        end

        r_chk_addr <= r_addr;
        r_rd_valid <= r_valid[r_addr];

        if (r_chk && hit && !r_found) begin
            r_match_idx <= r_chk_addr;
            r_hit_data  <= r_rd_data;
        end
        if (r_chk && !r_rd_valid && !r_free) begin
            r_free_idx <= r_chk_addr;
        end

        if (wb_fire) begin
            r_status    <= wb_status;
            r_read_data <= wb_rdata;
        end
    end

    // table memories, one read or one write per cycle
    always_ff @(posedge i_clk) begin
        if (wb_fire && wb_write) begin
            mem_name[wb_idx] <= norm_key;
            mem_data[wb_idx] <= r_wdata;
        end
        if (rd_en) begin
            r_rd_name <= mem_name[r_addr];
            r_rd_data <= mem_data[r_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_read_data = r_read_data;

endmodule

`default_nettype wire

FILE: hdl/nkts_norm.sv
// byte-serial name normalizer: clears bytes after the first zero byte, flags bad names
// depends on nkts_pkg
`default_nettype none

module nkts_norm #(
    parameter int unsigned NAME_CHARS = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [nkts_pkg::KEY_IN_BITS-1:0]   i_key,
    output nkts_pkg::t_norm_stat                    o_stat,
    output logic      [8*NAME_CHARS-1:0]            o_key
);
    import nkts_pkg::*;

    localparam int unsigned KEY_BITS = 8 * NAME_CHARS;

    logic [KEY_IN_BITS-1:0] r_sh;
    logic [KEY_IN_BITS-1:0] r_acc;
    logic [2:0]             r_cnt;
    logic                   r_busy;
    logic                   r_ended;
    logic                   r_bad;
    logic                   r_done;

    logic [7:0] cur_byte;
    logic       cur_zero;
    logic       past_limit;

    assign cur_byte   = r_sh[7:0];
    assign cur_zero   = (cur_byte == 8'h00);
    assign past_limit = ({1'b0, r_cnt} >= 4'(NAME_CHARS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= 3'd0;
            r_ended <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= 3'd0;
                r_ended <= 1'b0;
                r_bad   <= 1'b0;
            end else if (r_busy) begin
                if (!r_ended && cur_zero) begin
                    r_ended <= 1'b1;
                    if (r_cnt == 3'd0) begin
                        r_bad <= 1'b1;
                    end
                end
                if (!r_ended && !cur_zero && past_limit) begin
                    r_bad <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // payload shift lines, one byte per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh <= i_key;
        end else if (r_busy) begin
            r_sh  <= {8'h00, r_sh[KEY_IN_BITS-1:8]};
            r_acc <= {(r_ended || cur_zero) ? 8'h00 : cur_byte, r_acc[KEY_IN_BITS-1:8]};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.bad  = r_bad;
    assign o_key       = r_acc[KEY_BITS-1:0];

endmodule

`default_nettype wire

FILE: hdl/nkts_check.sv
// port-level checks for the name keyed table store and the bind that attaches them
// depends on nkts_pkg and name_keyed_table_store
`default_nettype none

module nkts_check (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic [1:0]                        o_status,
    input wire logic [nkts_pkg::DATA_IN_BITS-1:0] o_read_data
);
    import nkts_pkg::*;

    // result held while the far side stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
                                          && $stable(o_read_data)))
        else $error("result changed while stalled");

    // one request in work at a time
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request channel open right after a transfer");

    // data only comes with an ok status
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_data != '0) |-> (o_status == ST_OK))
        else $error("read data with a failing status");

    // a new result only comes out of a busy block
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in work");

endmodule

bind name_keyed_table_store nkts_check u_nkts_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_read_data (o_read_data)
);

`default_nettype wire
